### sv/assert_macros.svh
// Assertion macros shared by the frame buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CAFB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CAFB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cafb_pkg.sv
// Shared types, constants and helpers for the clipped alpha frame buffer.
package cafb_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFG_W = 9;
    localparam logic [CFG_W-1:0] FRAME_RESET = 9'd256;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [31:0] SCANLINE_COLOR = 32'h6600_0000;
    localparam logic [31:0] BLACK_COLOR    = 32'hFF00_0000;

    typedef enum logic [2:0] {
        MODE_PUT   = 3'd0,
        MODE_BLEND = 3'd1,
        MODE_GET   = 3'd2,
        MODE_FILL  = 3'd3,
        MODE_RECT  = 3'd4,
        MODE_SCAN  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_BLEND,
        OP_READ
    } pix_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        rect_w;
        logic [15:0]        rect_h;
        logic [31:0]        pixel_color;
    } cmd_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] color;
    } res_t;

    // Address bits for one coordinate of a store dimension.
    function automatic int addr_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Exact floor(n / 255) for n up to 65279.
    function automatic logic [7:0] div255(input logic [15:0] n);
        logic [16:0] t;
        t = {1'b0, n} + {9'b0, n[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

### sv/cafb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cafb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/cafb_blend.sv
// Two-step alpha blend: register channel products, then divide by 255 and merge.
module cafb_blend #(
    parameter int AW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [AW-1:0] in_addr,
    input  logic [31:0]   src,
    input  logic [31:0]   dst,
    output logic          wb_valid,
    output logic [AW-1:0] wb_addr,
    output logic [31:0]   wb_data
);

    logic          valid_reg;
    logic [AW-1:0] addr_reg;
    logic [7:0]    dst_alpha_reg;
    logic [15:0]   prod_s_reg [3];
    logic [15:0]   prod_d_reg [3];
    logic [15:0]   prod_s_next [3];
    logic [15:0]   prod_d_next [3];
    logic [7:0]    alpha;
    logic [7:0]    inv_alpha;
    logic [15:0]   chan_sum [3];
    logic [23:0]   chan_out;

    assign alpha     = src[31:24];
    assign inv_alpha = 8'd255 - alpha;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_s_next[c] = {8'b0, src[8*c +: 8]} * {8'b0, alpha};
            prod_d_next[c] = {8'b0, dst[8*c +: 8]} * {8'b0, inv_alpha};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= in_addr;
        dst_alpha_reg <= dst[31:24];
        for (int c = 0; c < 3; c++)
        begin
            prod_s_reg[c] <= prod_s_next[c];
            prod_d_reg[c] <= prod_d_next[c];
        end
    end

    // Sum stays below 65026, so 16 bits hold it.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            chan_sum[c]        = prod_s_reg[c] + prod_d_reg[c];
            chan_out[8*c +: 8] = cafb_pkg::div255(chan_sum[c]);
        end
    end

    assign wb_valid = valid_reg;
    assign wb_addr  = addr_reg;
    assign wb_data  = {dst_alpha_reg, chan_out};

endmodule

### sv/cafb_seq.sv
// Command sequencer: clips each command to a pixel rectangle and walks it through the store.
module cafb_seq #(
    parameter int MAX_WIDTH  = cafb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cafb_pkg::DEF_MAX_HEIGHT,
    localparam int XW  = cafb_pkg::addr_bits(MAX_WIDTH),
    localparam int YW  = cafb_pkg::addr_bits(MAX_HEIGHT),
    localparam int AW  = XW + YW
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [cafb_pkg::CFG_W-1:0]  frame_width,
    input  logic [cafb_pkg::CFG_W-1:0]  frame_height,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  cafb_pkg::cmd_t              cmd,
    input  logic                        out_free,
    output cafb_pkg::res_t              res,
    output logic                        ram_we,
    output logic [AW-1:0]               ram_waddr,
    output logic [31:0]                 ram_wdata,
    output logic [AW-1:0]               ram_raddr,
    input  logic [31:0]                 ram_rdata
);

    localparam int CXW = $clog2(MAX_WIDTH + 1);
    localparam int CYW = $clog2(MAX_HEIGHT + 2);

    cafb_pkg::state_t  state_reg, state_next;
    cafb_pkg::cmd_t    cmd_reg, cmd_next;
    cafb_pkg::pix_op_t op_reg, op_next;
    cafb_pkg::pix_op_t p1_op_reg, p1_op_next;
    logic              p1_valid_reg, p1_valid_next;
    logic [AW-1:0]     p1_addr_reg, p1_addr_next;
    logic [31:0]       color_reg, color_next;
    logic [31:0]       result_reg, result_next;
    logic              step2_reg, step2_next;
    logic [CXW-1:0]    x_start_reg, x_start_next;
    logic [CXW-1:0]    x_end_reg, x_end_next;
    logic [CXW-1:0]    cur_x_reg, cur_x_next;
    logic [CYW-1:0]    y_end_reg, y_end_next;
    logic [CYW-1:0]    cur_y_reg, cur_y_next;

    logic signed [17:0] w_s, h_s, x_s, y_s, lx, ly;
    logic signed [17:0] x_lo, x_hi, y_lo, y_hi;
    logic               empty;
    logic [CXW-1:0]     x_inc;
    logic [CYW-1:0]     y_inc;
    logic               x_last, y_last;
    logic [AW-1:0]      issue_addr;
    logic               wr_direct;
    logic               wb_valid;
    logic [AW-1:0]      wb_addr;
    logic [31:0]        wb_data;

    // Clip the command to the active area.
    always_comb
    begin
        w_s = ({9'b0, frame_width} > 18'(MAX_WIDTH)) ? 18'(MAX_WIDTH) : {9'b0, frame_width};
        h_s = ({9'b0, frame_height} > 18'(MAX_HEIGHT)) ? 18'(MAX_HEIGHT)
                                                       : {9'b0, frame_height};
        unique case (cmd_reg.mode) inside
            cafb_pkg::MODE_PUT, cafb_pkg::MODE_BLEND, cafb_pkg::MODE_GET:
            begin
                x_s = 18'(cmd_reg.pos_x);
                y_s = 18'(cmd_reg.pos_y);
                lx  = 18'sd1;
                ly  = 18'sd1;
            end
            cafb_pkg::MODE_FILL:
            begin
                x_s = 18'sd0;
                y_s = 18'sd0;
                lx  = w_s;
                ly  = h_s;
            end
            cafb_pkg::MODE_RECT:
            begin
                x_s = 18'(cmd_reg.pos_x);
                y_s = 18'(cmd_reg.pos_y);
                lx  = {2'b00, cmd_reg.rect_w};
                ly  = {2'b00, cmd_reg.rect_h};
            end
            cafb_pkg::MODE_SCAN:
            begin
                x_s = 18'sd0;
                y_s = 18'sd1;
                lx  = w_s;
                ly  = h_s - 18'sd1;
            end
            default:
            begin
                x_s = 18'sd0;
                y_s = 18'sd0;
                lx  = 18'sd0;
                ly  = 18'sd0;
            end
        endcase
        x_lo = (x_s < 18'sd0) ? 18'sd0 : x_s;
        y_lo = (y_s < 18'sd0) ? 18'sd0 : y_s;
        x_hi = x_s + lx;
        y_hi = y_s + ly;
        if (x_hi > w_s)
        begin
            x_hi = w_s;
        end
        if (y_hi > h_s)
        begin
            y_hi = h_s;
        end
        empty = (x_lo >= x_hi) || (y_lo >= y_hi);
    end

    assign issue_addr = {cur_y_reg[YW-1:0], cur_x_reg[XW-1:0]};
    assign x_inc      = cur_x_reg + CXW'(1);
    assign y_inc      = cur_y_reg + (step2_reg ? CYW'(2) : CYW'(1));
    assign x_last     = (x_inc == x_end_reg);
    assign y_last     = (y_inc >= y_end_reg);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        op_next       = op_reg;
        color_next    = color_reg;
        result_next   = result_reg;
        step2_next    = step2_reg;
        x_start_next  = x_start_reg;
        x_end_next    = x_end_reg;
        y_end_next    = y_end_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        p1_valid_next = 1'b0;
        p1_op_next    = op_reg;
        p1_addr_next  = issue_addr;
        cmd_ready     = 1'b0;
        wr_direct     = 1'b0;
        res.valid     = 1'b0;
        res.color     = result_reg;

        // Capture get data in the cycle after the read issue.
        if (p1_valid_reg && (p1_op_reg == cafb_pkg::OP_READ))
        begin
            result_next = ram_rdata;
        end

        unique case (state_reg)
            cafb_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = cafb_pkg::ST_SETUP;
                end
            end
            cafb_pkg::ST_SETUP:
            begin
                unique case (cmd_reg.mode) inside
                    cafb_pkg::MODE_BLEND, cafb_pkg::MODE_SCAN: op_next = cafb_pkg::OP_BLEND;
                    cafb_pkg::MODE_GET:                        op_next = cafb_pkg::OP_READ;
                    default:                                   op_next = cafb_pkg::OP_WRITE;
                endcase
                color_next   = (cmd_reg.mode == cafb_pkg::MODE_SCAN) ? cafb_pkg::SCANLINE_COLOR
                                                                      : cmd_reg.pixel_color;
                result_next  = (cmd_reg.mode == cafb_pkg::MODE_GET) ? cafb_pkg::BLACK_COLOR
                                                                     : 32'd0;
                step2_next   = (cmd_reg.mode == cafb_pkg::MODE_SCAN);
                x_start_next = x_lo[CXW-1:0];
                x_end_next   = x_hi[CXW-1:0];
                y_end_next   = y_hi[CYW-1:0];
                cur_x_next   = x_lo[CXW-1:0];
                cur_y_next   = y_lo[CYW-1:0];
                state_next   = empty ? cafb_pkg::ST_DONE : cafb_pkg::ST_WALK;
            end
            cafb_pkg::ST_WALK:
            begin
                wr_direct     = (op_reg == cafb_pkg::OP_WRITE);
                p1_valid_next = (op_reg != cafb_pkg::OP_WRITE);
                if (x_last)
                begin
                    cur_x_next = x_start_reg;
                    cur_y_next = y_inc;
                    if (y_last)
                    begin
                        state_next = cafb_pkg::ST_DRAIN;
                    end
                end
                else
                begin
                    cur_x_next = x_inc;
                end
            end
            cafb_pkg::ST_DRAIN:
            begin
                // Hold until the last read and write-back have retired.
                if (!p1_valid_reg && !wb_valid)
                begin
                    state_next = cafb_pkg::ST_DONE;
                end
            end
            cafb_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    res.valid  = 1'b1;
                    state_next = cafb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cafb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cafb_pkg::ST_IDLE;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        op_reg      <= op_next;
        color_reg   <= color_next;
        result_reg  <= result_next;
        step2_reg   <= step2_next;
        x_start_reg <= x_start_next;
        x_end_reg   <= x_end_next;
        y_end_reg   <= y_end_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        p1_op_reg   <= p1_op_next;
        p1_addr_reg <= p1_addr_next;
    end

    cafb_blend #(
        .AW(AW)
    ) u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (p1_valid_reg && (p1_op_reg == cafb_pkg::OP_BLEND)),
        .in_addr  (p1_addr_reg),
        .src      (color_reg),
        .dst      (ram_rdata),
        .wb_valid (wb_valid),
        .wb_addr  (wb_addr),
        .wb_data  (wb_data)
    );

    // A command either writes directly or blends, never both.
    assign ram_we    = wb_valid || wr_direct;
    assign ram_waddr = wb_valid ? wb_addr : issue_addr;
    assign ram_wdata = wb_valid ? wb_data : color_reg;
    assign ram_raddr = issue_addr;

endmodule

### sv/clipped_alpha_framebuffer_top.sv
// Top level of the clipped alpha frame buffer: config registers, result register, store.
//
// Channel   Handshake             Payload
// in        in_valid / in_ready   mode, pos_x, pos_y, rect_w, rect_h, pixel_color
// out       out_valid / out_ready read_color
// cfg       cfg_we                cfg_index, cfg_data
//
// A command passes through setup, a pixel walk over the store, a drain of the last
// read or blend, and finish; a command that covers nothing skips the walk and drain.
// The walk covers one pixel per cycle; scanlines walk only the odd rows.
// The store's read data is registered, so reads and blend write-backs finish in the drain.
// No clearing pass: the store is undefined until written, ready right after reset.
// A waiting result stalls only the finish of the next command, not its acceptance.
`include "assert_macros.svh"

module clipped_alpha_framebuffer_top #(
    parameter int MAX_WIDTH  = cafb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cafb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 mode,
    input  logic signed [15:0]         pos_x,
    input  logic signed [15:0]         pos_y,
    input  logic [15:0]                rect_w,
    input  logic [15:0]                rect_h,
    input  logic [31:0]                pixel_color,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [31:0]                read_color,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [cafb_pkg::CFG_W-1:0] cfg_data
);

    localparam int XW        = cafb_pkg::addr_bits(MAX_WIDTH);
    localparam int YW        = cafb_pkg::addr_bits(MAX_HEIGHT);
    localparam int AW        = XW + YW;
    localparam int RAM_DEPTH = 2 ** AW;

    logic [cafb_pkg::CFG_W-1:0] frame_width_reg;
    logic [cafb_pkg::CFG_W-1:0] frame_height_reg;
    logic                       out_valid_reg;
    logic [31:0]                read_color_reg;
    cafb_pkg::cmd_t             cmd;
    cafb_pkg::res_t             res;
    logic                       out_free;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [31:0]                ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [31:0]                ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= cafb_pkg::FRAME_RESET;
            frame_height_reg <= cafb_pkg::FRAME_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cafb_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                cafb_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:                    frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    assign cmd.mode        = cafb_pkg::mode_t'(mode);
    assign cmd.pos_x       = pos_x;
    assign cmd.pos_y       = pos_y;
    assign cmd.rect_w      = rect_w;
    assign cmd.rect_h      = rect_h;
    assign cmd.pixel_color = pixel_color;

    assign out_free = !out_valid_reg || out_ready;

    cafb_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .cmd_valid    (in_valid),
        .cmd_ready    (in_ready),
        .cmd          (cmd),
        .out_free     (out_free),
        .res          (res),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    cafb_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result register: load on a finished command, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            read_color_reg <= res.color;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_color = read_color_reg;

    `CAFB_ASSERT_IMP(a_res_slot_free, clk, rst_n, res.valid, !out_valid_reg || out_ready, "result finished while output register occupied")
    `CAFB_ASSERT_NXT(a_no_instant_res, clk, rst_n, in_valid && in_ready, !res.valid, "result in the cycle after acceptance")
    `CAFB_ASSERT_IMP(a_out_from_res, clk, rst_n, $rose(out_valid_reg), $past(res.valid), "output valid without a finished command")

endmodule

### verif/cafb_checker.sv
// Checker for the frame buffer: shadow frame store, read-back prediction and compare.
module cafb_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [2:0]                 mode,
    input  logic signed [15:0]         pos_x,
    input  logic signed [15:0]         pos_y,
    input  logic [15:0]                rect_w,
    input  logic [15:0]                rect_h,
    input  logic [31:0]                pixel_color,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [31:0]                read_color,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [cafb_pkg::CFG_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         results_seen,
    output int                         pending
);

    localparam int STRIDE = cafb_pkg::DEF_MAX_WIDTH;

    logic [31:0]                shadow_fb [0:cafb_pkg::DEF_MAX_WIDTH*cafb_pkg::DEF_MAX_HEIGHT-1];
    logic [cafb_pkg::CFG_W-1:0] span_w;
    logic [cafb_pkg::CFG_W-1:0] span_h;
    logic [31:0]                expected_reads [$];
    logic [31:0]                want_color;

    function automatic bit in_frame(input int x, input int y, input int w, input int h);
        return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    // Mix src over dst by the source alpha; keep the destination alpha byte.
    function automatic logic [31:0] blend_over(input logic [31:0] src, input logic [31:0] dst);
        int unsigned a;
        int unsigned s;
        int unsigned d;
        int unsigned c;
        int          sh;
        logic [31:0] res;
        a = 32'(src[31:24]);
        res = {dst[31:24], 24'h000000};
        for (sh = 0; sh < 24; sh += 8)
        begin
            s = (src >> sh) & 32'hFF;
            d = (dst >> sh) & 32'hFF;
            c = (s * a + d * (255 - a)) / 255;
            res[sh +: 8] = c[7:0];
        end
        return res;
    endfunction

    // Update the shadow store for one command and return the read_color it should produce.
    function automatic logic [31:0] apply_command(
        input logic [2:0]         op,
        input logic signed [15:0] px,
        input logic signed [15:0] py,
        input logic [15:0]        rw,
        input logic [15:0]        rh,
        input logic [31:0]        color
    );
        int x;
        int y;
        int w;
        int h;
        int x0;
        int y0;
        int x1;
        int y1;
        int i;
        int j;
        logic [31:0] rd;
        x = int'(px);
        y = int'(py);
        w = (span_w > cafb_pkg::DEF_MAX_WIDTH) ? cafb_pkg::DEF_MAX_WIDTH : int'(span_w);
        h = (span_h > cafb_pkg::DEF_MAX_HEIGHT) ? cafb_pkg::DEF_MAX_HEIGHT : int'(span_h);
        rd = '0;
        case (op)
            cafb_pkg::MODE_PUT:
                if (in_frame(x, y, w, h))
                    shadow_fb[y * STRIDE + x] = color;
            cafb_pkg::MODE_BLEND:
                if (in_frame(x, y, w, h))
                    shadow_fb[y * STRIDE + x] = blend_over(color, shadow_fb[y * STRIDE + x]);
            cafb_pkg::MODE_GET:
                rd = in_frame(x, y, w, h) ? shadow_fb[y * STRIDE + x] : cafb_pkg::BLACK_COLOR;
            cafb_pkg::MODE_FILL:
                for (j = 0; j < h; j++)
                    for (i = 0; i < w; i++)
                        shadow_fb[j * STRIDE + i] = color;
            cafb_pkg::MODE_RECT:
            begin
                // Exact corner arithmetic, then clip to the active area.
                x0 = (x < 0) ? 0 : x;
                y0 = (y < 0) ? 0 : y;
                x1 = x + int'(rw);
                y1 = y + int'(rh);
                if (x1 > w)
                    x1 = w;
                if (y1 > h)
                    y1 = h;
                for (j = y0; j < y1; j++)
                    for (i = x0; i < x1; i++)
                        shadow_fb[j * STRIDE + i] = color;
            end
            cafb_pkg::MODE_SCAN:
                for (j = 1; j < h; j += 2)
                    for (i = 0; i < w; i++)
                        shadow_fb[j * STRIDE + i] =
                            blend_over(cafb_pkg::SCANLINE_COLOR, shadow_fb[j * STRIDE + i]);
            default:
                ;
        endcase
        return rd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_w = cafb_pkg::FRAME_RESET;
            span_h = cafb_pkg::FRAME_RESET;
            expected_reads.delete();
            fail_count = 0;
            results_seen = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == cafb_pkg::CFG_FRAME_WIDTH)
                    span_w = cfg_data;
                else
                    span_h = cfg_data;
            end
            // Retire the oldest expectation before queuing a new one.
            if (out_valid && out_ready)
            begin
                if (expected_reads.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: read_color %h with nothing pending",
                                 read_color);
                end
                else
                begin
                    want_color = expected_reads.pop_front();
                    if (read_color !== want_color)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result %0d mismatch: read_color expected %h, actual %h",
                                     results_seen, want_color, read_color);
                    end
                end
                results_seen++;
            end
            if (in_valid && in_ready)
                expected_reads.push_back(apply_command(mode, pos_x, pos_y, rect_w, rect_h,
                                                       pixel_color));
            pending = expected_reads.size();
        end
    end

endmodule

### verif/tb.sv
// Testbench top for the frame buffer: clock, reset, stimulus, back-pressure and verdict.
module tb;

    localparam int          CFG_W        = cafb_pkg::CFG_W;
    localparam logic [2:0]  MODE_RSVD6   = 3'd6;
    localparam logic [2:0]  MODE_RSVD7   = 3'd7;
    localparam int          NUM_PHASES   = 13;
    localparam int          PHASE_ITEMS  = 115;
    localparam int          QUIET_PHASE  = 5;
    localparam int          SQUEEZE_PHASE = 1;
    localparam int          HOLD_CYCLES  = 400;
    localparam int unsigned CYCLE_LIMIT  = 10000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         mode = cafb_pkg::MODE_PUT;
    logic signed [15:0] pos_x = '0;
    logic signed [15:0] pos_y = '0;
    logic [15:0]        rect_w = '0;
    logic [15:0]        rect_h = '0;
    logic [31:0]        pixel_color = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [31:0]        read_color;
    logic               cfg_we = 1'b0;
    logic               cfg_index = cafb_pkg::CFG_FRAME_WIDTH;
    logic [CFG_W-1:0]   cfg_data = '0;

    int fail_count;
    int results_seen;
    int pending;

    int sent = 0;
    int op_count [0:7] = '{0, 0, 0, 0, 0, 0, 0, 0};
    bit gaps_on = 1'b1;
    bit hold_off = 1'b0;
    int cur_w = cafb_pkg::DEF_MAX_WIDTH;
    int cur_h = cafb_pkg::DEF_MAX_HEIGHT;

    // Frame settings per phase: tiny, zero, oversized and full-size among them.
    int frame_plan_w [0:NUM_PHASES-1] = '{1, 16, 0, 7, 256, 9, 511, 3, 511, 256, 1, 32, 5};
    int frame_plan_h [0:NUM_PHASES-1] = '{1, 16, 5, 0, 256, 13, 3, 511, 511, 1, 256, 8, 5};

    always #4 clk = ~clk;

    clipped_alpha_framebuffer_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rect_w      (rect_w),
        .rect_h      (rect_h),
        .pixel_color (pixel_color),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_color  (read_color),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    cafb_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .rect_w       (rect_w),
        .rect_h       (rect_h),
        .pixel_color  (pixel_color),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_color   (read_color),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_seen (results_seen),
        .pending      (pending)
    );

    // Offer one command and hold it until the transaction completes.
    task automatic send_cmd(
        input logic [2:0]         op,
        input logic signed [15:0] x,
        input logic signed [15:0] y,
        input logic [15:0]        rw,
        input logic [15:0]        rh,
        input logic [31:0]        color
    );
        while (gaps_on && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= op;
        pos_x       <= x;
        pos_y       <= y;
        rect_w      <= rw;
        rect_h      <= rh;
        pixel_color <= color;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        op_count[op]++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (results_seen != sent)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly inside the active area, some on its edges, a few anywhere in 16 bits.
    function automatic logic signed [15:0] pick_coord(input int lim);
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return (lim > 0) ? 16'($urandom_range(lim - 1)) : 16'($urandom_range(3));
        if (r < 88)
        begin
            case ($urandom_range(3))
                0:       return -16'sd1;
                1:       return 16'(lim);
                2:       return 16'(lim - 1);
                default: return 16'sd0;
            endcase
        end
        return 16'($urandom);
    endfunction

    task automatic random_cmd();
        int                 r;
        int                 area;
        logic [2:0]         op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        rw;
        logic [15:0]        rh;
        logic [31:0]        color;
        area = cur_w * cur_h;
        r = $urandom_range(99);
        if (r < 25)
            op = cafb_pkg::MODE_PUT;
        else if (r < 45)
            op = cafb_pkg::MODE_BLEND;
        else if (r < 72)
            op = cafb_pkg::MODE_GET;
        else if (r < 86)
            op = cafb_pkg::MODE_RECT;
        else if (r < 89)
            op = (area <= 1024) ? cafb_pkg::MODE_FILL : cafb_pkg::MODE_GET;
        else if (r < 92)
            op = (area <= 1024) ? cafb_pkg::MODE_SCAN : cafb_pkg::MODE_GET;
        else if (r < 98)
            op = cafb_pkg::MODE_GET;
        else
            op = (r == 98) ? MODE_RSVD6 : MODE_RSVD7;
        x = pick_coord(cur_w);
        y = pick_coord(cur_h);
        if ($urandom_range(9) < 8)
        begin
            rw = 16'($urandom_range(cur_w + 2));
            rh = 16'($urandom_range(cur_h + 2));
            if (area > 1024)
            begin
                rw = 16'($urandom_range(12));
                rh = 16'($urandom_range(12));
            end
        end
        else
        begin
            rw = 16'($urandom);
            rh = 16'($urandom);
            // Keep big-frame rectangles to a few rows or columns.
            if (area > 1024)
            begin
                if ($urandom_range(1))
                    rh = 16'($urandom_range(3));
                else
                    rw = 16'($urandom_range(3));
            end
        end
        color = $urandom;
        r = $urandom_range(9);
        if (r == 0)
            color[31:24] = 8'h00;
        else if (r == 1)
            color[31:24] = 8'hFF;
        send_cmd(op, x, y, rw, rh, color);
    endtask

    initial
    begin : result_sink
        int k;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                out_ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            else
            begin
                out_ready <= !gaps_on || ($urandom_range(99) >= 13);
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-frame fill first so that no later read touches an unwritten pixel.
        send_cmd(cafb_pkg::MODE_FILL, 0, 0, 16'hFFFF, 16'hFFFF, 32'h8040_2010);
        send_cmd(cafb_pkg::MODE_PUT, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_cmd(cafb_pkg::MODE_PUT, 255, 255, 0, 0, 32'h0000_0000);
        send_cmd(cafb_pkg::MODE_PUT, -1, 5, 0, 0, 32'h1234_5678);
        send_cmd(cafb_pkg::MODE_PUT, 0, 256, 0, 0, 32'h1234_5678);
        send_cmd(cafb_pkg::MODE_PUT, -32768, 32767, 0, 0, 32'hDEAD_BEEF);
        send_cmd(cafb_pkg::MODE_BLEND, 0, 0, 0, 0, 32'h00AB_CDEF);
        send_cmd(cafb_pkg::MODE_BLEND, 255, 255, 0, 0, 32'hFFFF_FFFF);
        send_cmd(cafb_pkg::MODE_BLEND, 1, 1, 0, 0, 32'h80FF_00FF);
        send_cmd(cafb_pkg::MODE_GET, 0, 0, 0, 0, 32'h0);
        send_cmd(cafb_pkg::MODE_GET, 255, 255, 0, 0, 32'h0);
        send_cmd(cafb_pkg::MODE_GET, 1, 1, 0, 0, 32'h0);
        send_cmd(cafb_pkg::MODE_GET, 256, 0, 0, 0, 32'h0);
        send_cmd(cafb_pkg::MODE_GET, 32767, -32768, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(cafb_pkg::MODE_RECT, -5, -5, 10, 10, 32'hFF00_FF00);
        send_cmd(cafb_pkg::MODE_RECT, 250, 250, 20, 20, 32'h1122_3344);
        send_cmd(cafb_pkg::MODE_RECT, 10, 10, 0, 5, 32'hAAAA_AAAA);
        send_cmd(cafb_pkg::MODE_RECT, 10, 10, 5, 0, 32'h5555_5555);
        send_cmd(cafb_pkg::MODE_RECT, -32768, 100, 16'hFFFF, 1, 32'h0F0F_0F0F);
        send_cmd(cafb_pkg::MODE_GET, 4, 4, 0, 0, 32'h0);
        send_cmd(cafb_pkg::MODE_GET, 100, 100, 0, 0, 32'h0);
        send_cmd(cafb_pkg::MODE_SCAN, 0, 0, 0, 0, 32'h0);
        send_cmd(cafb_pkg::MODE_GET, 0, 1, 0, 0, 32'h0);
        send_cmd(MODE_RSVD6, 3, 3, 3, 3, 32'h7777_7777);
        send_cmd(MODE_RSVD7, 3, 1, 3, 3, 32'h7777_7777);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            write_reg(cafb_pkg::CFG_FRAME_WIDTH, CFG_W'(frame_plan_w[p]));
            write_reg(cafb_pkg::CFG_FRAME_HEIGHT, CFG_W'(frame_plan_h[p]));
            cur_w = (frame_plan_w[p] > cafb_pkg::DEF_MAX_WIDTH) ? cafb_pkg::DEF_MAX_WIDTH
                                                                 : frame_plan_w[p];
            cur_h = (frame_plan_h[p] > cafb_pkg::DEF_MAX_HEIGHT) ? cafb_pkg::DEF_MAX_HEIGHT
                                                                  : frame_plan_h[p];
            gaps_on = (p != QUIET_PHASE);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // Stall the result side while commands keep coming.
                if (p == SQUEEZE_PHASE && k == 20)
                    hold_off = 1'b1;
                random_cmd();
            end
        end

        settle();
        repeat (16) @(posedge clk);

        $display("Run drove %0d commands over %0d frame settings (zero, one, full, oversized).",
                 sent, NUM_PHASES + 1);
        $display("put %0d, blend %0d, get %0d, fill %0d, rect %0d, scanlines %0d, unused %0d;"
                 , op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
                 op_count[5], op_count[6] + op_count[7]);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
